// ===== hdl/shuffled_block_map_unit_defines.svh =====
// ----------------------------------------------------------------------------
// shuffled block map assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_BLOCK_MAP_UNIT_DEFINES_SVH
`define SHUFFLED_BLOCK_MAP_UNIT_DEFINES_SVH

// implication checked on every clock, off during reset
`define SBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SBM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// shuffled block map package
// shared constants, command codes and the divider interface types
// ----------------------------------------------------------------------------
`default_nettype none
package sbm_pkg;
    localparam int MAX_BLOCKS = 4096;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int SIZE_W     = 13;
    localparam int DATA_W     = 48;
    localparam int DIV_W      = 64;

    localparam logic [1:0] CMD_RESET   = 2'd0;
    localparam logic [1:0] CMD_SHUFFLE = 2'd1;
    localparam logic [1:0] CMD_MAP     = 2'd2;

    localparam logic CFG_SIZE = 1'b0;
    localparam logic CFG_SEED = 1'b1;

    localparam logic [47:0] LCG_MUL    = 48'h5DEECE66D;
    localparam logic [47:0] LCG_ADD    = 48'hB;
    localparam logic [47:0] SEED_RESET = 48'd20017429951246;
    localparam logic [12:0] SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [DIV_W-1:0]  rem;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/sbm_divider.sv =====
// ----------------------------------------------------------------------------
// sbm divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module sbm_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sbm_pkg::div_req_t      req,
    output sbm_pkg::div_rsp_t      rsp
);
    localparam int CNT_W = $clog2(sbm_pkg::DIV_W + 1);

    logic [sbm_pkg::DIV_W-1:0] quot_reg, rem_reg, dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg, done_reg;
    logic [sbm_pkg::DIV_W:0]   trial;
    logic [sbm_pkg::DIV_W:0]   diff;

    assign trial = {rem_reg, quot_reg[sbm_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(sbm_pkg::DIV_W);
                quot_reg <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[sbm_pkg::DIV_W])
                begin
                    rem_reg  <= diff[sbm_pkg::DIV_W-1:0];
                    quot_reg <= {quot_reg[sbm_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial[sbm_pkg::DIV_W-1:0];
                    quot_reg <= {quot_reg[sbm_pkg::DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;
endmodule
`default_nettype wire

// ===== hdl/sbm_rng.sv =====
// ----------------------------------------------------------------------------
// sbm rng
// rand48 generator, multiply split over three 16-bit partial products
// ----------------------------------------------------------------------------
`default_nettype none
module sbm_rng (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [47:0] seed,
    input  wire logic        step,
    output logic             done,
    output logic [30:0]      draw
);
    logic [47:0] state_reg, acc_reg;
    logic [1:0]  ph_reg;
    logic        busy_reg, done_reg;
    logic [15:0] part;
    logic [51:0] part_prod;
    logic [47:0] prod;

    // acc = sum over 16-bit slices of state times multiplier, shifted
    always_comb
    begin
        case (ph_reg)
            2'd0:    part = state_reg[15:0];
            2'd1:    part = state_reg[31:16];
            default: part = state_reg[47:32];
        endcase
        part_prod = part * sbm_pkg::LCG_MUL[35:0];
        prod      = 48'(part_prod) << (16 * ph_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbm_pkg::SEED_RESET;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ph_reg    <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                state_reg <= seed;
            end
            else if (step && !busy_reg)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
                acc_reg  <= sbm_pkg::LCG_ADD;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + prod;
                ph_reg  <= ph_reg + 1'b1;
                if (ph_reg == 2'd2)
                begin
                    state_reg <= acc_reg + prod;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign draw = state_reg[47:17];
endmodule
`default_nettype wire

// ===== hdl/shuffled_block_map_unit.sv =====
// ----------------------------------------------------------------------------
// shuffled block map unit
// permutation table with shuffle and position map over a shared divider
// ----------------------------------------------------------------------------
// reset table: one identity entry written per cycle, over all MAX_BLOCKS entries
// shuffle: size-1 swap steps, each with two rand48 draws, a divide and a table swap
// map: divide, table read, 16-bit multiply slices; size zero gives a draw modulo random_limit
// one item at a time; in_ready low while an item is in work or its result waits
// async reset: table reads as identity after a clearing pass over all MAX_BLOCKS entries
`default_nettype none
module shuffled_block_map_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [47:0] position,
    input  wire logic [47:0] random_limit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [47:0]      mapped_position
);
    localparam int IW = sbm_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SH_TOP, S_SH_DRAW1, S_SH_DRAW2, S_SH_DIV, S_SH_RDI,
        S_SH_SWAP, S_MAP_DIV, S_MAP_RD, S_MAP_MUL, S_RND_DRAW1, S_RND_DRAW2,
        S_RND_DIV, S_OUT
    } state_t;

    state_t              state_reg;
    logic [12:0]         size_reg;
    logic [47:0]         seed_reg;
    logic [IW:0]         cnt_reg;     // clear index / shuffle i
    logic [30:0]         hi_reg;
    logic [47:0]         lim_reg, res_reg, quot_reg;
    logic [IW-1:0]       jidx_reg;
    logic [IW-1:0]       vi_reg;
    logic [1:0]          mph_reg;
    logic                out_valid_reg;

    // table memory, one port each side
    logic [IW-1:0] mem [sbm_pkg::MAX_BLOCKS];
    logic [IW-1:0] rd_data_reg;
    logic          we;
    logic [IW-1:0] waddr, wdata, raddr;

    // quotient slice times size for the map multiply
    logic [15:0]   q_slice;
    logic [28:0]   q_prod;

    logic [12:0]   eff_size;
    assign eff_size = (size_reg > 13'(sbm_pkg::MAX_BLOCKS)) ? 13'(sbm_pkg::MAX_BLOCKS) : size_reg;

    sbm_pkg::div_req_t dreq;
    sbm_pkg::div_rsp_t drsp;
    logic  rng_step, rng_done;
    logic [30:0] draw;

    sbm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    sbm_rng u_rng (.clk(clk), .rst_n(rst_n),
        .load(state_reg == S_IDLE && in_valid && cmd == sbm_pkg::CMD_RESET),
        .seed(seed_reg), .step(rng_step), .done(rng_done), .draw(draw));

    always_comb
    begin
        case (mph_reg)
            2'd0:    q_slice = quot_reg[15:0];
            2'd1:    q_slice = quot_reg[31:16];
            default: q_slice = quot_reg[47:32];
        endcase
        q_prod = q_slice * eff_size;
    end

    always_comb
    begin
        rng_step = 1'b0;
        dreq     = '0;
        we       = 1'b0;
        waddr    = cnt_reg[IW-1:0];
        wdata    = cnt_reg[IW-1:0];
        raddr    = jidx_reg;
        case (state_reg)
            S_CLEAR:     we = 1'b1;
            S_SH_TOP:    rng_step = 1'b1;
            S_SH_DRAW1:  rng_step = rng_done;
            S_RND_DRAW1: rng_step = rng_done;
            S_IDLE:      rng_step = in_valid && cmd == sbm_pkg::CMD_MAP && eff_size == '0;
            S_SH_DRAW2:
            begin
                dreq.start    = rng_done;
                dreq.dividend = {2'b0, hi_reg, draw};
                dreq.divisor  = 64'(cnt_reg);
            end
            S_RND_DRAW2:
            begin
                dreq.start    = rng_done;
                dreq.dividend = {2'b0, hi_reg, draw};
                dreq.divisor  = {16'b0, lim_reg};
            end
            S_SH_DIV:    raddr = IW'(cnt_reg - 1'b1);
            S_SH_RDI:    raddr = jidx_reg;
            S_SH_SWAP:
            begin
                // writes top first, then j
                we    = 1'b1;
                waddr = (mph_reg == 2'd0) ? IW'(cnt_reg - 1'b1) : jidx_reg;
                wdata = (mph_reg == 2'd0) ? rd_data_reg : vi_reg;
            end
            S_MAP_DIV:   raddr = drsp.rem[IW-1:0];
            default:     ;
        endcase
        if (state_reg == S_IDLE && in_valid && cmd == sbm_pkg::CMD_MAP && eff_size != '0)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = {16'b0, position};
            dreq.divisor  = 64'(eff_size);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            size_reg      <= sbm_pkg::SIZE_RESET;
            seed_reg      <= sbm_pkg::SEED_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mph_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sbm_pkg::CFG_SIZE)
                    size_reg <= cfg_data[12:0];
                else
                    seed_reg <= cfg_data;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[IW-1:0] == '1)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= cnt_reg[IW];
                        res_reg       <= '0;
                        cnt_reg       <= '0;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_reg <= '0;
                        lim_reg <= random_limit;
                        case (cmd)
                            sbm_pkg::CMD_RESET:
                            begin
                                // mark as command clear: top bit set flags a result
                                cnt_reg   <= {1'b1, {IW{1'b0}}};
                                state_reg <= S_CLEAR;
                            end
                            sbm_pkg::CMD_SHUFFLE:
                            begin
                                cnt_reg   <= (IW+1)'(eff_size);
                                state_reg <= (eff_size > 13'd1) ? S_SH_TOP : S_OUT;
                                out_valid_reg <= !(eff_size > 13'd1);
                            end
                            sbm_pkg::CMD_MAP:
                                state_reg <= (eff_size != '0) ? S_MAP_DIV : S_RND_DRAW1;
                            default:
                            begin
                                state_reg     <= S_OUT;
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SH_TOP:    state_reg <= S_SH_DRAW1;
                S_SH_DRAW1:
                    if (rng_done)
                    begin
                        hi_reg    <= draw;
                        state_reg <= S_SH_DRAW2;
                    end
                S_SH_DRAW2:  if (rng_done) state_reg <= S_SH_DIV;
                S_SH_DIV:
                    if (drsp.done)
                    begin
                        vi_reg    <= rd_data_reg;
                        jidx_reg  <= drsp.rem[IW-1:0];
                        state_reg <= S_SH_RDI;
                    end
                S_SH_RDI:
                begin
                    state_reg <= S_SH_SWAP;
                    mph_reg   <= 2'd0;
                end
                S_SH_SWAP:
                begin
                    mph_reg <= mph_reg + 1'b1;
                    if (mph_reg == 2'd1)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == (IW+1)'(2))
                        begin
                            state_reg     <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_SH_TOP;
                    end
                end
                S_MAP_DIV:
                    if (drsp.done)
                    begin
                        quot_reg  <= drsp.quot[47:0];
                        res_reg   <= '0;
                        mph_reg   <= '0;
                        state_reg <= S_MAP_RD;
                    end
                S_MAP_RD:
                begin
                    res_reg   <= 48'(rd_data_reg);
                    state_reg <= S_MAP_MUL;
                end
                S_MAP_MUL:
                begin
                    // quotient times size, one 16-bit slice per cycle
                    case (mph_reg)
                        2'd0: res_reg <= res_reg + 48'(q_prod);
                        2'd1: res_reg <= res_reg + (48'(q_prod) << 16);
                        default: res_reg <= res_reg + (48'(q_prod) << 32);
                    endcase
                    mph_reg <= mph_reg + 1'b1;
                    if (mph_reg == 2'd2)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_RND_DRAW1:
                    if (rng_done)
                    begin
                        hi_reg    <= draw;
                        state_reg <= S_RND_DRAW2;
                    end
                S_RND_DRAW2:
                    if (rng_done)
                    begin
                        if (lim_reg == '0)
                        begin
                            state_reg     <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_RND_DIV;
                    end
                S_RND_DIV:
                    if (drsp.done)
                    begin
                        res_reg       <= drsp.rem[47:0];
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                S_OUT:
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign mapped_position = res_reg;
endmodule
`default_nettype wire

// ===== hdl/sbm_checker.sv =====
// ----------------------------------------------------------------------------
// sbm checker
// port-level checks on the shuffled block map unit
// ----------------------------------------------------------------------------
`default_nettype none
`include "shuffled_block_map_unit_defines.svh"
module sbm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  cmd,
    input wire logic [47:0] mapped_position
);
    // one item at a time: no new transfer while a result waits
    `SBM_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
    // a transfer in drops ready next cycle
    `SBM_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready)
    // stalled result holds
    `SBM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mapped_position))
    // non-map commands give zero
    `SBM_ASSERT_NXT(a_zero_nonmap, in_valid && in_ready && cmd != sbm_pkg::CMD_MAP,
        !out_valid || mapped_position == '0)
endmodule
bind shuffled_block_map_unit sbm_checker u_sbm_checker (.*);
`default_nettype wire

// ===== sim/tb_shuffled_block_map_unit.sv =====
// ----------------------------------------------------------------------------
// shuffled block map unit testbench
// directed table then random traffic, each result checked against a local
// model of the permutation table, the rand48 generator and the position map
// ----------------------------------------------------------------------------
`default_nettype none
module tb_shuffled_block_map_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [47:0] ALL_ONES = {48{1'b1}};
    // a full 4096-entry shuffle makes no transfer until its result
    localparam int STALL_LIMIT = 1_500_000;
    localparam int RAND_ITEMS = 800;

    typedef struct {
        bit          is_cfg;
        logic        cfg_sel;
        logic [47:0] data;
        logic [1:0]  op;
        logic [47:0] pos;
        logic [47:0] lim;
        bit          chk;
        logic [47:0] want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [47:0] position;
    logic [47:0] random_limit;
    logic        out_valid;
    logic        out_ready;
    logic [47:0] mapped_position;

    // local copy of block state and registers
    logic [sbm_pkg::IDX_W-1:0]  perm_model [sbm_pkg::MAX_BLOCKS];
    logic [47:0]                lcg_state;
    logic [sbm_pkg::SIZE_W-1:0] size_reg;
    logic [47:0]                seed_reg;

    logic [47:0] pending_maps [$];
    stim_row_t   dir_rows [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;

    shuffled_block_map_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .position        (position),
        .random_limit    (random_limit),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mapped_position (mapped_position)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report(input string what, input logic [47:0] want,
                          input logic [47:0] got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // rand48 step, returns bits 47..17 of the new state
    function automatic logic [30:0] lcg_draw();
        lcg_state = lcg_state * sbm_pkg::LCG_MUL + sbm_pkg::LCG_ADD;
        return lcg_state[47:17];
    endfunction

    function automatic logic [63:0] lcg_draw62();
        logic [30:0] hi;
        logic [30:0] lo;
        hi = lcg_draw();
        lo = lcg_draw();
        return {2'b00, hi, lo};
    endfunction

    function automatic void model_reset();
        size_reg = sbm_pkg::SIZE_RESET;
        seed_reg = sbm_pkg::SEED_RESET;
        lcg_state = sbm_pkg::SEED_RESET;
        for (int k = 0; k < sbm_pkg::MAX_BLOCKS; k++)
            perm_model[k] = sbm_pkg::IDX_W'(k);
    endfunction

    // updates table and generator, returns the expected mapped position
    function automatic logic [47:0] predict_block_map(input logic [1:0] op,
                                                     input logic [47:0] pos,
                                                     input logic [47:0] lim);
        logic [63:0]               eff;
        logic [63:0]               j;
        logic [63:0]               r;
        logic [63:0]               q;
        logic [sbm_pkg::IDX_W-1:0] t;
        logic [47:0]               res;
        eff = (size_reg > sbm_pkg::MAX_BLOCKS) ? 64'(sbm_pkg::MAX_BLOCKS) : 64'(size_reg);
        res = '0;
        case (op)
            sbm_pkg::CMD_RESET:
            begin
                for (int k = 0; k < sbm_pkg::MAX_BLOCKS; k++)
                    perm_model[k] = sbm_pkg::IDX_W'(k);
                lcg_state = seed_reg;
            end
            sbm_pkg::CMD_SHUFFLE:
            begin
                for (longint unsigned i = eff; i > 1; i--)
                begin
                    j = lcg_draw62() % i;
                    t = perm_model[i-1];
                    perm_model[i-1] = perm_model[j];
                    perm_model[j] = t;
                end
            end
            sbm_pkg::CMD_MAP:
            begin
                if (eff != 0)
                begin
                    q = {16'd0, pos} / eff;
                    res = 48'(64'(perm_model[{16'd0, pos} % eff]) + q * eff);
                end
                else
                begin
                    r = lcg_draw62();
                    res = (lim != 0) ? 48'(r % {16'd0, lim}) : '0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // drop valid and let every pending result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [47:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == sbm_pkg::CFG_SIZE)
            size_reg = value[sbm_pkg::SIZE_W-1:0];
        else
            seed_reg = value;
        @(posedge clk);
    endtask

    // one input transfer; the prediction is queued on acceptance
    task automatic send_item(input logic [1:0] op, input logic [47:0] pos,
                             input logic [47:0] lim, input bit chk,
                             input logic [47:0] want);
        logic [47:0] pred;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        position     <= pos;
        random_limit <= lim;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_block_map(op, pos, lim);
        if (chk && pred !== want)
            report("model vs table", want, pred);
        pending_maps.push_back(chk ? want : pred);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [sbm_pkg::SIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0: return '0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'($urandom_range(4097, 8191));
            4: return 13'($urandom_range(33, 4095));
            default: return 13'($urandom_range(2, 32));
        endcase
    endfunction

    // receiver: random back-pressure and in-order compare
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_maps.size() == 0)
                report("unexpected result", '0, mapped_position);
            else
            begin
                if (mapped_position !== pending_maps[0])
                    report("mapped_position", pending_maps[0], mapped_position);
                void'(pending_maps.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("** shuffled_block_map_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [sbm_pkg::SIZE_W-1:0] sz;
        logic [63:0]                cur_size;
        logic [1:0]                 op;
        logic [47:0]                pos;
        logic [47:0]                lim;
        int                         pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        position = '0;
        random_limit = '0;
        mismatches = 0;
        send_idle_pct = 30;
        recv_idle_pct = 69;
        model_reset();

        // directed table: values typed in only where obvious
        // identity table after reset, full-size extremes
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd0, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd4095, 48'd0, 1, 48'd4095});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd4096, 48'd0, 1, 48'd4096});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, ALL_ONES, ALL_ONES, 1, ALL_ONES});
        // unused command code leaves state alone
        dir_rows.push_back('{0, 0, 0, CMD_UNUSED, ALL_ONES, ALL_ONES, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_RESET, ALL_ONES, 48'd0, 1, 48'd0});
        // size of one: shuffle is a no-op, map passes position through
        dir_rows.push_back('{1, sbm_pkg::CFG_SIZE, 48'd1, 0, 0, 0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_SHUFFLE, 48'd0, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd12345, 48'd0, 1, 48'd12345});
        // random position mode, zero limit still takes the draws
        dir_rows.push_back('{1, sbm_pkg::CFG_SIZE, 48'd0, 0, 0, 0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, ALL_ONES, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd0, 48'd1, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd0, ALL_ONES, 0, 0});
        dir_rows.push_back('{1, sbm_pkg::CFG_SEED, 48'd0, 0, 0, 0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_RESET, 48'd0, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd0, ALL_ONES, 0, 0});
        dir_rows.push_back('{1, sbm_pkg::CFG_SEED, ALL_ONES, 0, 0, 0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_RESET, 48'd0, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd0, 48'd12345, 0, 0});
        // size above the table saturates; one full-table shuffle
        dir_rows.push_back('{1, sbm_pkg::CFG_SIZE, 48'd8191, 0, 0, 0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, ALL_ONES, 48'd0, 1, ALL_ONES});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_SHUFFLE, 48'd0, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, 48'd4097, 48'd0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, ALL_ONES, 48'd0, 0, 0});
        // odd size: result wraps at 48 bits
        dir_rows.push_back('{1, sbm_pkg::CFG_SIZE, 48'd3, 0, 0, 0, 0, 0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_SHUFFLE, 48'd0, 48'd0, 1, 48'd0});
        dir_rows.push_back('{0, 0, 0, sbm_pkg::CMD_MAP, ALL_ONES, 48'd0, 0, 0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n])
        begin
            if (dir_rows[n].is_cfg)
                write_reg(dir_rows[n].cfg_sel, dir_rows[n].data);
            else
                send_item(dir_rows[n].op, dir_rows[n].pos, dir_rows[n].lim,
                          dir_rows[n].chk, dir_rows[n].want);
        end

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 30 : 0;
            for (int n = 0; n < RAND_ITEMS / 3; n++)
            begin
                if (n % 40 == 0)
                begin
                    // upper data bits are random, the register keeps 13
                    sz = pick_size();
                    write_reg(sbm_pkg::CFG_SIZE, {35'(rand48()), sz});
                    if ($urandom_range(1) == 1)
                        write_reg(sbm_pkg::CFG_SEED, rand48());
                end
                cur_size = (size_reg > sbm_pkg::MAX_BLOCKS) ? 64'(sbm_pkg::MAX_BLOCKS)
                                                            : 64'(size_reg);
                pick = $urandom_range(99);
                if (pick < 8)
                    op = sbm_pkg::CMD_RESET;
                else if (pick < 22 && cur_size <= 32)
                    op = sbm_pkg::CMD_SHUFFLE;
                else if (pick < 26)
                    op = CMD_UNUSED;
                else
                    op = sbm_pkg::CMD_MAP;
                pos = ($urandom_range(1) == 1) ? rand48()
                                               : 48'($urandom_range(0, 3 * 4096 + 7));
                case ($urandom_range(3))
                    0: lim = '0;
                    1: lim = 48'($urandom_range(1, 100));
                    default: lim = rand48();
                endcase
                send_item(op, pos, lim, 0, '0);
            end
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("** shuffled_block_map_unit: PASSED **");
        else
            $display("** shuffled_block_map_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
